// ----- sv/two_level_branch_predictor_defines.svh -----
// assertion macros for the two-level branch predictor
`ifndef TWO_LEVEL_BRANCH_PREDICTOR_DEFINES_SVH
`define TWO_LEVEL_BRANCH_PREDICTOR_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define TLBP_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("tlbp assertion failed");
`define TLBP_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> cons) \
    else $error("tlbp assertion failed");
`else
`define TLBP_ASSERT_NOW(lbl, ante, cons)
`define TLBP_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

// ----- sv/tlbp_pkg.sv -----
// shared types, constants and counter update for the branch predictor
package tlbp_pkg;

  localparam int unsigned HistIndexBitsDef = 15;
  localparam int unsigned PatternPcBitsDef = 15;
  localparam int unsigned HistLengthDef    = 2;

  // instructions are 8 bytes apart
  localparam int unsigned WordShift = 3;
  localparam logic [31:0] PcStep    = 32'd8;

  localparam logic [1:0] CtrReset = 2'b01;
  localparam logic [1:0] CtrMin   = 2'b00;
  localparam logic [1:0] CtrMax   = 2'b11;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_HIST,
    ST_CTR
  } state_e;

  // two-bit saturating counter step towards the outcome
  function automatic logic [1:0] ctr_update(input logic [1:0] ctr, input logic taken);
    logic [1:0] res;
    res = ctr;
    if (taken) begin
      if (ctr != CtrMax) res = ctr + 2'd1;
    end else begin
      if (ctr != CtrMin) res = ctr - 2'd1;
    end
    return res;
  endfunction

endpackage

// ----- sv/tlbp_ram.sv -----
// simple dual-port synchronous ram, one write and one registered read port
module tlbp_ram #(
  parameter int unsigned WIDTH     = 2,
  parameter int unsigned ADDR_BITS = 15
) (
  input  logic                 clk_i,
  input  logic                 we_i,
  input  logic [ADDR_BITS-1:0] waddr_i,
  input  logic [WIDTH-1:0]     wdata_i,
  input  logic [ADDR_BITS-1:0] raddr_i,
  output logic [WIDTH-1:0]     rdata_o
);

  localparam longint unsigned Depth = 64'd1 << ADDR_BITS;

  logic [WIDTH-1:0] mem [Depth];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- sv/two_level_branch_predictor.sv -----
// Two-level adaptive branch predictor (per-address history, per-address
// pattern tables). Each request is one resolved branch; done_o pulses for one
// cycle with the prediction, the outcome and whether it was right, and it
// must be taken in that cycle. Each request passes through the ST_HIST and
// ST_CTR states: the history ram read and the pattern counter ram read happen
// in series, each through a registered read port, and the result is registered.
// A new request may be accepted in the cycle the previous result is shown.
// After reset busy stays high for a clearing pass that sweeps the deeper of
// the history ram and the pattern counter ram, which sets histories to zero
// and counters to weakly not taken.
`include "two_level_branch_predictor_defines.svh"

module two_level_branch_predictor #(
  parameter int unsigned HISTORY_INDEX_BITS = tlbp_pkg::HistIndexBitsDef,
  parameter int unsigned PATTERN_PC_BITS    = tlbp_pkg::PatternPcBitsDef,
  parameter int unsigned HISTORY_LENGTH     = tlbp_pkg::HistLengthDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [31:0] pc_i,
  input  logic [31:0] next_address_i,
  output logic        done_o,
  output logic        predicted_taken_o,
  output logic        actual_taken_o,
  output logic        correct_o
);

  localparam int unsigned CtrBits = PATTERN_PC_BITS + HISTORY_LENGTH;
  localparam int unsigned PwBits  =
    (HISTORY_INDEX_BITS > PATTERN_PC_BITS) ? HISTORY_INDEX_BITS : PATTERN_PC_BITS;
  localparam int unsigned ClrBits =
    (HISTORY_INDEX_BITS > CtrBits) ? HISTORY_INDEX_BITS : CtrBits;

  tlbp_pkg::state_e state_q, state_d;

  logic [ClrBits-1:0]        clr_q, clr_d;
  logic [PwBits-1:0]         pword_q;
  logic                      taken_q;
  logic [CtrBits-1:0]        cidx_q;
  logic                      done_q;
  logic                      pred_q, actual_q, correct_q;

  logic                      accept;
  logic                      taken;
  logic [31:0]               pc_step;
  logic                      clr_last;

  logic                      hist_we;
  logic [HISTORY_INDEX_BITS-1:0] hist_waddr, hist_raddr;
  logic [HISTORY_LENGTH-1:0] hist_wdata, hist_rd;
  logic [HISTORY_LENGTH:0]   hist_shift;

  logic                      ctr_we;
  logic [CtrBits-1:0]        ctr_waddr, ctr_raddr;
  logic [1:0]                ctr_wdata, ctr_rd;
  logic [PwBits+HISTORY_LENGTH-1:0] cidx_wide;

  assign accept   = start && !busy;
  assign pc_step  = pc_i + tlbp_pkg::PcStep;
  assign taken    = (next_address_i != pc_step);
  assign clr_last = (clr_q == '1);

  assign hist_shift = {hist_rd, taken_q};
  assign cidx_wide  = {pword_q, hist_rd};

  // ---------------------------------------------------------------- state
  always_comb begin
    state_d = state_q;
    case (state_q)
      tlbp_pkg::ST_CLEAR: if (clr_last) state_d = tlbp_pkg::ST_IDLE;
      tlbp_pkg::ST_IDLE:  if (start) state_d = tlbp_pkg::ST_HIST;
      tlbp_pkg::ST_HIST:  state_d = tlbp_pkg::ST_CTR;
      tlbp_pkg::ST_CTR:   state_d = tlbp_pkg::ST_IDLE;
      default:            state_d = tlbp_pkg::ST_IDLE;
    endcase
  end

  // ---------------------------------------------------------------- outputs
  always_comb begin
    busy       = 1'b1;
    clr_d      = clr_q;
    hist_we    = 1'b0;
    hist_waddr = pword_q[HISTORY_INDEX_BITS-1:0];
    hist_wdata = hist_shift[HISTORY_LENGTH-1:0];
    hist_raddr = pc_i[tlbp_pkg::WordShift +: HISTORY_INDEX_BITS];
    ctr_we     = 1'b0;
    ctr_waddr  = cidx_q;
    ctr_wdata  = tlbp_pkg::ctr_update(ctr_rd, taken_q);
    ctr_raddr  = cidx_wide[CtrBits-1:0];
    case (state_q)
      tlbp_pkg::ST_CLEAR: begin
        clr_d      = clr_q + 1'b1;
        // the smaller store is done once the sweep passes its depth
        hist_we    = ((clr_q >> HISTORY_INDEX_BITS) == '0);
        hist_waddr = clr_q[HISTORY_INDEX_BITS-1:0];
        hist_wdata = '0;
        ctr_we     = ((clr_q >> CtrBits) == '0);
        ctr_waddr  = clr_q[CtrBits-1:0];
        ctr_wdata  = tlbp_pkg::CtrReset;
      end
      tlbp_pkg::ST_IDLE: begin
        busy = 1'b0;
      end
      tlbp_pkg::ST_HIST: begin
        hist_we = 1'b1;
      end
      tlbp_pkg::ST_CTR: begin
        ctr_we = 1'b1;
      end
      default: begin
        busy = 1'b1;
      end
    endcase
  end

  // ---------------------------------------------------------------- registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= tlbp_pkg::ST_CLEAR;
      clr_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      done_q  <= (state_q == tlbp_pkg::ST_CTR);
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      pword_q <= pc_i[tlbp_pkg::WordShift +: PwBits];
      taken_q <= taken;
    end
    if (state_q == tlbp_pkg::ST_HIST) begin
      cidx_q <= ctr_raddr;
    end
    if (state_q == tlbp_pkg::ST_CTR) begin
      pred_q    <= ctr_rd[1];
      actual_q  <= taken_q;
      correct_q <= (ctr_rd[1] == taken_q);
    end
  end

  assign done_o            = done_q;
  assign predicted_taken_o = pred_q;
  assign actual_taken_o    = actual_q;
  assign correct_o         = correct_q;

  // ---------------------------------------------------------------- stores
  tlbp_ram #(
    .WIDTH    (HISTORY_LENGTH),
    .ADDR_BITS(HISTORY_INDEX_BITS)
  ) u_hist_ram (
    .clk_i  (clk_i),
    .we_i   (hist_we),
    .waddr_i(hist_waddr),
    .wdata_i(hist_wdata),
    .raddr_i(hist_raddr),
    .rdata_o(hist_rd)
  );

  tlbp_ram #(
    .WIDTH    (2),
    .ADDR_BITS(CtrBits)
  ) u_ctr_ram (
    .clk_i  (clk_i),
    .we_i   (ctr_we),
    .waddr_i(ctr_waddr),
    .wdata_i(ctr_wdata),
    .raddr_i(ctr_raddr),
    .rdata_o(ctr_rd)
  );

  // ---------------------------------------------------------------- checks
  `TLBP_ASSERT_NEXT(a_req_gives_result, start && !busy, ##2 done_o)
  `TLBP_ASSERT_NOW(a_result_when_idle, done_o, !busy && state_q == tlbp_pkg::ST_IDLE)
  `TLBP_ASSERT_NEXT(a_ctr_then_idle, state_q == tlbp_pkg::ST_CTR, done_o && !busy)

endmodule

// ----- tb/tb_top.sv -----
// self-checking testbench for the two-level branch predictor, driven by resolved branch requests
module tb_top;

  localparam int unsigned HistIndexBits = tlbp_pkg::HistIndexBitsDef;
  localparam int unsigned PatternPcBits = tlbp_pkg::PatternPcBitsDef;
  localparam int unsigned HistLen       = tlbp_pkg::HistLengthDef;
  localparam int unsigned CtrBits       = PatternPcBits + HistLen;
  localparam int unsigned HistDepth     = 1 << HistIndexBits;
  localparam int unsigned CtrDepth      = 1 << CtrBits;
  // the clearing pass after reset is the longest quiet stretch of a correct run
  localparam int unsigned ClearCycles   = (HistDepth > CtrDepth) ? HistDepth : CtrDepth;
  localparam int unsigned StallLimit    = 4 * ClearCycles + 1000;
  localparam int unsigned DrainCycles   = 8;
  localparam int unsigned MaxReported   = 10;

  typedef struct packed {
    logic [31:0] pc;
    logic        predicted_taken;
    logic        actual_taken;
    logic        correct;
  } branch_verdict_t;

  logic        clk_i          = 1'b0;
  logic        rst_ni         = 1'b0;
  logic        start          = 1'b0;
  logic [31:0] pc_i           = '0;
  logic [31:0] next_address_i = '0;
  logic        busy;
  logic        done_o;
  logic        predicted_taken_o;
  logic        actual_taken_o;
  logic        correct_o;

  // shadow copy of the predictor tables
  logic [HistLen-1:0] branch_history [HistDepth];
  logic [1:0]         pattern_ctr    [CtrDepth];

  branch_verdict_t verdict_q[$];
  int unsigned     mismatches   = 0;
  int unsigned     stall_cycles = 0;
  int unsigned     idle_pct     = 0;
  logic [31:0]     hot_pc [8];

  two_level_branch_predictor uut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start            (start),
    .busy             (busy),
    .pc_i             (pc_i),
    .next_address_i   (next_address_i),
    .done_o           (done_o),
    .predicted_taken_o(predicted_taken_o),
    .actual_taken_o   (actual_taken_o),
    .correct_o        (correct_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic branch_verdict_t predict_branch(input logic [31:0] pc,
                                                     input logic [31:0] nxt);
    logic [31:0]              word;
    logic [HistIndexBits-1:0] hidx;
    logic [CtrBits-1:0]       cidx;
    logic [HistLen-1:0]       hist;
    logic [HistLen:0]         hist_next;
    logic [1:0]               ctr;
    logic [31:0]              fall_through;
    logic                     taken;
    branch_verdict_t          v;
    word         = pc >> tlbp_pkg::WordShift;
    hidx         = word[HistIndexBits-1:0];
    hist         = branch_history[hidx];
    cidx         = {word[PatternPcBits-1:0], hist};
    ctr          = pattern_ctr[cidx];
    fall_through = pc + tlbp_pkg::PcStep;
    taken        = (nxt != fall_through);
    v.pc              = pc;
    v.predicted_taken = ctr[1];
    v.actual_taken    = taken;
    v.correct         = (ctr[1] == taken);
    if (taken) begin
      if (ctr != tlbp_pkg::CtrMax) ctr = ctr + 2'd1;
    end else begin
      if (ctr != tlbp_pkg::CtrMin) ctr = ctr - 2'd1;
    end
    pattern_ctr[cidx]    = ctr;
    // newest outcome in bit 0, oldest falls off the top
    hist_next            = {hist, taken};
    branch_history[hidx] = hist_next[HistLen-1:0];
    return v;
  endfunction

  function automatic logic [31:0] taken_target(input logic [31:0] pc);
    logic [31:0] t;
    case ($urandom_range(0, 3))
      0: t = $urandom;
      1: t = pc - tlbp_pkg::PcStep * $urandom_range(1, 16);
      2: t = pc + 2 * tlbp_pkg::PcStep;
      default: t = pc;
    endcase
    return t;
  endfunction

  task automatic note_mismatch(input string msg);
    if (mismatches < MaxReported) $display("mismatch: %s", msg);
    mismatches++;
  endtask

  // one request: optional idle gap, then hold start until the block takes it
  task automatic resolve_branch(input logic [31:0] pc, input logic [31:0] nxt);
    while ($urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
    start          <= 1'b1;
    pc_i           <= pc;
    next_address_i <= nxt;
    do @(posedge clk_i); while (busy);
    verdict_q.push_back(predict_branch(pc, nxt));
  endtask

  task automatic test_field_extremes();
    resolve_branch(32'h0000_0000, 32'h0000_0008);
    resolve_branch(32'h0000_0000, 32'h0000_0000);
    resolve_branch(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    // fall-through address wraps past the top of the address space
    resolve_branch(32'hFFFF_FFFF, 32'h0000_0007);
    resolve_branch(32'hFFFF_FFF8, 32'h0000_0000);
  endtask

  task automatic test_high_pc_aliasing();
    logic [31:0] base;
    logic [31:0] alias_pc;
    base     = 32'h0001_2340;
    alias_pc = base | 32'hFFFC_0000;
    repeat (4) resolve_branch(base, base - tlbp_pkg::PcStep);
    resolve_branch(alias_pc, alias_pc - tlbp_pkg::PcStep);
    resolve_branch(alias_pc, alias_pc + tlbp_pkg::PcStep);
  endtask

  task automatic test_counter_saturation();
    logic [31:0] pc;
    pc = 32'h0003_FFF8;
    repeat (5) resolve_branch(pc, 32'h0000_1000);
    repeat (5) resolve_branch(pc, pc + tlbp_pkg::PcStep);
  endtask

  task automatic test_random_traffic(input int unsigned pct, input int unsigned count);
    int unsigned sent;
    int unsigned trips;
    logic [31:0] pc;
    logic [31:0] nxt;
    sent     = 0;
    idle_pct = pct;
    while (sent < count) begin
      if ($urandom_range(0, 99) < 75) begin
        // loop-shaped run: 1 to 6 taken branches to assorted targets, then the exit
        pc = hot_pc[$urandom_range(0, 7)];
        if ($urandom_range(0, 3) == 0) pc[31:18] = 14'($urandom);
        trips = $urandom_range(1, 6);
        repeat (trips) begin
          resolve_branch(pc, taken_target(pc));
          sent++;
        end
        resolve_branch(pc, pc + tlbp_pkg::PcStep);
        sent++;
      end else begin
        pc  = $urandom;
        nxt = $urandom_range(0, 1) ? pc + tlbp_pkg::PcStep : $urandom;
        resolve_branch(pc, nxt);
        sent++;
      end
    end
  endtask

  always @(posedge clk_i) begin
    branch_verdict_t exp_v;
    if (rst_ni && done_o) begin
      if (verdict_q.size() == 0) begin
        note_mismatch($sformatf("result with none expected: pred %0b act %0b ok %0b",
                                predicted_taken_o, actual_taken_o, correct_o));
      end else begin
        exp_v = verdict_q.pop_front();
        if (predicted_taken_o !== exp_v.predicted_taken ||
            actual_taken_o !== exp_v.actual_taken || correct_o !== exp_v.correct) begin
          note_mismatch($sformatf("pc %08h exp pred %0b act %0b ok %0b, got %0b %0b %0b",
                                  exp_v.pc, exp_v.predicted_taken, exp_v.actual_taken,
                                  exp_v.correct, predicted_taken_o, actual_taken_o,
                                  correct_o));
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((start && !busy) || done_o) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= StallLimit) begin
      $display("two_level_branch_predictor regression: fail");
      $finish;
    end
  end

  initial begin
    for (int i = 0; i < HistDepth; i++) branch_history[i] = '0;
    for (int i = 0; i < CtrDepth; i++) pattern_ctr[i] = tlbp_pkg::CtrReset;
    foreach (hot_pc[i]) hot_pc[i] = $urandom;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_field_extremes();
    test_high_pc_aliasing();
    test_counter_saturation();
    test_random_traffic(0, 250);
    test_random_traffic(64, 250);
    test_random_traffic(37, 250);

    start <= 1'b0;
    while (verdict_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    if (mismatches == 0 && verdict_q.size() == 0) begin
      $display("two_level_branch_predictor regression: pass");
    end else begin
      $display("two_level_branch_predictor regression: fail");
    end
    $finish;
  end

endmodule

// ----- files.f -----
+incdir+sv
sv/tlbp_pkg.sv
sv/tlbp_ram.sv
sv/two_level_branch_predictor.sv
tb/tb_top.sv
